>>> rtl/core/lz78c_pkg.sv
package lz78c_pkg;

  localparam int DICT_ENTRIES = 4096;
  localparam int CODE_W       = $clog2(DICT_ENTRIES);
  localparam int NFC_W        = CODE_W + 1;
  localparam int BYTE_W       = 8;

  // each cell of the row holds a small group of dictionary entries
  localparam int CELL_LG      = 4;
  localparam int CELL_ENTRIES = 1 << CELL_LG;
  localparam int CELL_W       = CODE_W - CELL_LG;
  localparam int NUM_CELLS    = 1 << CELL_W;

  // search token handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [CODE_W-1:0] code;
  } tok_t;

  // search key, held steady while a token walks the row
  typedef struct packed {
    logic [CODE_W-1:0] parent;
    logic [BYTE_W-1:0] data;
    logic [NFC_W-1:0]  limit;
  } key_t;

  // dictionary insert, seen by every cell
  typedef struct packed {
    logic              en;
    logic [CODE_W-1:0] addr;
    logic [CODE_W-1:0] parent;
    logic [BYTE_W-1:0] data;
  } wr_t;

endpackage

>>> rtl/core/lz78c_cell.sv
module lz78c_cell
  import lz78c_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CELL_W-1:0] cell_id,
  input  key_t              key,
  input  wr_t               wr,
  input  tok_t              tok_in,
  output tok_t              tok_out
);

  logic [CODE_W-1:0]       ent_parent_r [CELL_ENTRIES];
  logic [BYTE_W-1:0]       ent_data_r   [CELL_ENTRIES];
  logic [CELL_ENTRIES-1:0] match;
  logic [CELL_LG-1:0]      loc;
  tok_t                    tok_r;
  tok_t                    tok_nxt;

  for (genvar j = 0; j < CELL_ENTRIES; j++) begin : g_ent
    logic [CODE_W-1:0] idx;
    assign idx = {cell_id, CELL_LG'(j)};

    // only codes 1 .. next free code minus one are live
    assign match[j] = (idx != '0) && ({1'b0, idx} < key.limit) &&
                      (ent_parent_r[j] == key.parent) && (ent_data_r[j] == key.data);
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < CELL_ENTRIES; j++) begin
      if (wr.en && (wr.addr == {cell_id, CELL_LG'(j)})) begin
        ent_parent_r[j] <= wr.parent;
        ent_data_r[j]   <= wr.data;
      end
    end
  end

  // lowest matching entry in this group
  always_comb begin
    loc = '0;
    for (int j = CELL_ENTRIES - 1; j >= 0; j--) begin
      if (match[j]) begin
        loc = CELL_LG'(j);
      end
    end
  end

  // an earlier cell's hit has the lower code and wins
  always_comb begin
    tok_nxt.valid = tok_in.valid;
    tok_nxt.hit   = tok_in.hit | (|match);
    tok_nxt.code  = tok_in.hit ? tok_in.code : {cell_id, loc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

>>> rtl/core/lz78_compressor.sv
// a byte marked end of stream skips the search and its pair goes through S_EMIT to the
// outputs; any other byte is searched by the token walking the row of cells, 16 entries
// per cell, and on a miss its pair goes through S_EMIT the same way; in_stall holds off a
// new byte until the last one is through, and result stalls hold S_EMIT
// reset: synchronous, active low; clears phrase, free code count and control, not entries
module lz78_compressor
  import lz78c_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_end_of_stream,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CODE_W-1:0] out_phrase_code,
  output logic [BYTE_W-1:0] out_next_byte,
  output logic              out_final_pair
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CODE_W-1:0] cur_r, cur_nxt;
  logic [NFC_W-1:0]  nfc_r, nfc_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              eos_r, eos_nxt;
  logic              launch_r, launch_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0] out_code_r, out_code_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_final_r, out_final_nxt;

  logic              in_accept;
  logic              out_free;
  key_t              key;
  wr_t               wr;
  tok_t              tok_chain [NUM_CELLS+1];
  tok_t              tail;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign key.parent = cur_r;
  assign key.data   = byte_r;
  assign key.limit  = nfc_r;

  assign tok_chain[0].valid = launch_r;
  assign tok_chain[0].hit   = 1'b0;
  assign tok_chain[0].code  = '0;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    lz78c_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cell_id (CELL_W'(i)),
      .key     (key),
      .wr      (wr),
      .tok_in  (tok_chain[i]),
      .tok_out (tok_chain[i+1])
    );
  end

  assign tail = tok_chain[NUM_CELLS];

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    nfc_nxt       = nfc_r;
    byte_nxt      = byte_r;
    eos_nxt       = eos_r;
    launch_nxt    = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_code_nxt  = out_code_r;
    out_byte_nxt  = out_byte_r;
    out_final_nxt = out_final_r;
    wr.en         = 1'b0;
    wr.addr       = nfc_r[CODE_W-1:0];
    wr.parent     = cur_r;
    wr.data       = byte_r;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          byte_nxt = in_data_byte;
          eos_nxt  = in_end_of_stream;
          if (in_end_of_stream) begin
            state_nxt = S_EMIT;
          end else begin
            launch_nxt = 1'b1;
            state_nxt  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (tail.valid) begin
          if (tail.hit) begin
            cur_nxt   = tail.code;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_code_nxt  = cur_r;
          out_byte_nxt  = byte_r;
          out_final_nxt = eos_r;
          cur_nxt       = '0;
          if (eos_r) begin
            nfc_nxt = NFC_W'(1);
          end else if (nfc_r < NFC_W'(DICT_ENTRIES)) begin
            wr.en   = 1'b1;
            nfc_nxt = nfc_r + NFC_W'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      nfc_r       <= NFC_W'(1);
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      nfc_r       <= nfc_nxt;
      launch_r    <= launch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r      <= byte_nxt;
    eos_r       <= eos_nxt;
    out_code_r  <= out_code_nxt;
    out_byte_r  <= out_byte_nxt;
    out_final_r <= out_final_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_phrase_code = out_code_r;
  assign out_next_byte   = out_byte_r;
  assign out_final_pair  = out_final_r;

  a_nfc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (nfc_r != '0) && (nfc_r <= NFC_W'(DICT_ENTRIES)))
    else $error("free code count out of range");

  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tail.valid |-> (state_r == S_SCAN))
    else $error("search token left the row outside a scan");

  a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (nfc_r < NFC_W'(DICT_ENTRIES)) && !eos_r)
    else $error("insert into a full dictionary or on the final byte");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_free && eos_r) |=> (nfc_r == NFC_W'(1)) && (cur_r == '0))
    else $error("final pair did not clear the dictionary");

  a_eos_skips_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_end_of_stream) |=> (state_r == S_EMIT) && !launch_r)
    else $error("final byte started a search");

endmodule
